// File: rtl/gfsm_pkg.sv
// Shared types and constants for the greedy founder segment matcher.
// Used by gfsm_match, gfsm_result_queue and the top level; no dependencies.
`timescale 1ns / 1ps

package gfsm_pkg;

    // Number of founders that take part in the comparison (1 to 8).
    localparam int NUM_FOUNDERS = 8;

    localparam int ID_W     = 16;
    localparam int CHAR_W   = 8;
    localparam int POS_W    = 32;
    localparam int MASK_W   = 8;
    localparam int COLUMN_W = 64;

    // Mask with the low NUM_FOUNDERS bits set.
    localparam logic [MASK_W-1:0] ALL_FOUNDERS = MASK_W'((1 << NUM_FOUNDERS) - 1);

    // Most results that one character can cause.
    localparam int MAX_RESULTS = 3;

    // Result queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [1:0] res_count_t;

    typedef enum logic {
        KIND_RANGE     = 1'b0,
        KIND_NOT_FOUND = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [ID_W-1:0]    seq_id;
        logic [POS_W-1:0]   range_start;
        logic [POS_W-1:0]   range_end;
        logic [MASK_W-1:0]  founders;
        logic [CHAR_W-1:0]  offending_char;
        logic               end_of_results;
    } result_t;

    // Results of one character, in order, with their number.
    typedef struct packed {
        res_count_t                  count;
        result_t [MAX_RESULTS-1:0]   res;
    } result_group_t;

endpackage

// File: rtl/greedy_founder_segment_matcher_top.sv
// Top level of the greedy founder segment matcher: input register, matcher
// and result queue. Depends on gfsm_pkg, gfsm_match and gfsm_result_queue.
`timescale 1ns / 1ps

//  Channel | Direction | Content
//  s_*     | in        | one sequence character with the founder column, tlast = final char
//  m_*     | out       | one range or not-found result, tuser = kind, tlast = end of results
//
//  A request passes from the input register through the combinational matcher into
//  the result queue, whose entries hold the results for m_*; a queue without room
//  for a full group holds the request in the input register.
//  One request per cycle is taken while each causes at most one result and the output
//  does not stall; after a request that causes two or three results, the next request
//  waits in the input register until the four-entry queue has three free slots again.
//  Reset clears the matcher to all founders live at position zero and empties
//  the queue. A stalled output holds the result steady and backs up the input.

module greedy_founder_segment_matcher_top (
    input  logic         clk,
    input  logic         rst_n,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [87:0]  s_tdata,   // sequence_id[15:0], seq_char[23:16], founder_column[87:24]
    input  logic         s_tlast,   // final_char
    // Output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // out_sequence_id[15:0], range_start[47:16],
                                    // range_end[79:48], matching_founders[87:80],
                                    // offending_char[95:88]
    output logic         m_tuser,   // kind
    output logic         m_tlast    // end_of_results
);
    import gfsm_pkg::*;

    logic                in_valid_reg, in_valid_next;
    logic [ID_W-1:0]     id_reg;
    logic [CHAR_W-1:0]   char_reg;
    logic [COLUMN_W-1:0] column_reg;
    logic                final_reg;
    logic                room;
    logic                step;
    logic                take;
    result_group_t       group;
    result_t             head;

    // The held request moves on when the queue can take a full group.
    assign step     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || step;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            id_reg     <= s_tdata[15:0];
            char_reg   <= s_tdata[23:16];
            column_reg <= s_tdata[87:24];
            final_reg  <= s_tlast;
        end
    end

    gfsm_match u_match (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .sequence_id    (id_reg),
        .seq_char       (char_reg),
        .founder_column (column_reg),
        .final_char     (final_reg),
        .group          (group)
    );

    gfsm_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step),
        .group      (group),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (head)
    );

    // Output packing.
    assign m_tdata = {head.offending_char, head.founders, head.range_end,
                      head.range_start, head.seq_id};
    assign m_tuser = head.kind;
    assign m_tlast = head.end_of_results;

endmodule

// File: rtl/gfsm_match.sv
// Matching state (live mask, range start, position) and the logic that turns
// one character into its group of results. Depends on gfsm_pkg.
`timescale 1ns / 1ps

module gfsm_match (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [15:0]                  sequence_id,
    input  logic [7:0]                   seq_char,
    input  logic [63:0]                  founder_column,
    input  logic                         final_char,
    output gfsm_pkg::result_group_t      group
);
    import gfsm_pkg::*;

    logic [MASK_W-1:0] live_mask_reg, live_mask_next;
    logic [POS_W-1:0]  range_left_reg, range_left_next;
    logic [POS_W-1:0]  position_reg, position_next;

    logic [MASK_W-1:0] agree;
    logic [MASK_W-1:0] kept;
    logic [MASK_W-1:0] mask_after;
    logic [POS_W-1:0]  left_after;
    logic [POS_W-1:0]  pos_after;
    result_t [MAX_RESULTS-1:0] res;
    res_count_t        n;

    // Founders whose character equals the sequence character, compared in parallel.
    always_comb
    begin
        agree = '0;
        for (int k = 0; k < NUM_FOUNDERS; k++)
        begin
            agree[k] = (founder_column[8*k +: 8] == seq_char);
        end
    end

    assign kept = live_mask_reg & agree;

    // Build the result list in order: closed range, not-found error, final result.
    always_comb
    begin
        res        = '0;
        n          = '0;
        mask_after = kept;
        left_after = range_left_reg;
        pos_after  = position_reg + POS_W'(1);

        if (kept == '0)
        begin
            res[n].kind        = KIND_RANGE;
            res[n].seq_id      = sequence_id;
            res[n].range_start = range_left_reg;
            res[n].range_end   = position_reg;
            res[n].founders    = live_mask_reg;
            n                  = n + 2'd1;
            left_after         = position_reg;
            mask_after         = ALL_FOUNDERS & agree;
            if (mask_after == '0)
            begin
                res[n].kind           = KIND_NOT_FOUND;
                res[n].seq_id         = sequence_id;
                res[n].range_end      = position_reg;
                res[n].offending_char = seq_char;
                n                     = n + 2'd1;
            end
        end

        if (final_char)
        begin
            res[n].seq_id    = sequence_id;
            res[n].range_end = pos_after;
            if (mask_after == '0)
            begin
                res[n].kind           = KIND_NOT_FOUND;
                res[n].offending_char = seq_char;
            end
            else
            begin
                res[n].kind        = KIND_RANGE;
                res[n].range_start = left_after;
                res[n].founders    = mask_after;
            end
            n = n + 2'd1;
        end

        // Mark the last result of this character.
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res[i].end_of_results = (n != '0) && (2'(i) == n - 2'd1);
        end
    end

    assign group.count = n;
    assign group.res   = res;

    // Next state: the final character returns the matcher to its reset state.
    always_comb
    begin
        live_mask_next  = live_mask_reg;
        range_left_next = range_left_reg;
        position_next   = position_reg;
        if (step)
        begin
            if (final_char)
            begin
                live_mask_next  = ALL_FOUNDERS;
                range_left_next = '0;
                position_next   = '0;
            end
            else
            begin
                live_mask_next  = mask_after;
                range_left_next = left_after;
                position_next   = pos_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_mask_reg  <= ALL_FOUNDERS;
            range_left_reg <= '0;
            position_reg   <= '0;
        end
        else
        begin
            live_mask_reg  <= live_mask_next;
            range_left_reg <= range_left_next;
            position_reg   <= position_next;
        end
    end

endmodule

// File: rtl/gfsm_result_queue.sv
// Small result queue: takes up to three results in one cycle, hands out one
// result per cycle on the output stream while the output takes it. Depends on gfsm_pkg.
`timescale 1ns / 1ps

module gfsm_result_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  gfsm_pkg::result_group_t  group,
    output logic                     room,
    output logic                     out_valid,
    input  logic                     out_ready,
    output gfsm_pkg::result_t        out_result
);
    import gfsm_pkg::*;

    result_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    res_count_t        n_push;
    logic              pop;

    assign n_push     = push ? group.count : '0;
    assign out_valid  = (count_reg != '0);
    assign pop        = out_valid && out_ready;
    assign out_result = entry_reg[rd_ptr_reg];

    // Room for a full group of results, judged from the registered fill.
    assign room = (count_reg <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS));

    // Pointer and fill arithmetic.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(n_push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage: each result of the group goes to its own slot.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (2'(i) < n_push)
            begin
                entry_reg[wr_ptr_reg + QPTR_W'(i)] <= group.res[i];
            end
        end
    end

endmodule

// File: verif/testbench.sv
// Self-checking testbench for greedy_founder_segment_matcher_top: streams sequence
// characters with founder columns and checks every range or not-found result.
// Depends on gfsm_pkg and the RTL of the matcher top level.
`timescale 1ns / 1ps

module testbench;

    import gfsm_pkg::*;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_T = 8'h54;

    // One sequence character together with the founder characters at its position.
    typedef struct {
        logic [ID_W-1:0]     seq_id;
        logic [CHAR_W-1:0]   ch;
        logic [COLUMN_W-1:0] column;
        logic                last;
    } char_request_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [87:0]  s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    char_request_t pending_chars[$];
    result_t       expected_segments[$];
    int            error_count = 0;
    int            cycle_count = 0;
    logic          request_taken = 1'b0;
    logic          calm_stretch = 1'b0;

    // Predictor state: live founders, left bound of the open range, position.
    logic [MASK_W-1:0] live_founders = ALL_FOUNDERS;
    logic [POS_W-1:0]  open_range_left = '0;
    logic [POS_W-1:0]  char_position = '0;

    greedy_founder_segment_matcher_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("greedy_founder_segment_matcher_top test failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    function automatic result_t make_segment(input kind_t kind, input logic [ID_W-1:0] id,
                                             input logic [POS_W-1:0] start_pos,
                                             input logic [POS_W-1:0] stop_pos,
                                             input logic [MASK_W-1:0] founders,
                                             input logic [CHAR_W-1:0] ch);
        result_t r;
        r.kind           = kind;
        r.seq_id         = id;
        r.range_start    = start_pos;
        r.range_end      = stop_pos;
        r.founders       = founders;
        r.offending_char = ch;
        r.end_of_results = 1'b0;
        return r;
    endfunction

    // Work out the ranges and errors that one accepted character causes.
    task automatic predict_segments(input char_request_t req);
        logic [MASK_W-1:0] agree;
        logic [MASK_W-1:0] next_mask;
        result_t           batch[$];
        int                k;
        agree = '0;
        for (k = 0; k < NUM_FOUNDERS; k++)
            agree[k] = (req.column[8*k +: 8] == req.ch);
        next_mask = live_founders & agree;
        if (next_mask == '0)
        begin
            // Close the current range and rematch from all founders.
            batch.insert(batch.size(), make_segment(KIND_RANGE, req.seq_id, open_range_left,
                                                    char_position, live_founders, '0));
            open_range_left = char_position;
            next_mask = ALL_FOUNDERS & agree;
            if (next_mask == '0)
                batch.insert(batch.size(), make_segment(KIND_NOT_FOUND, req.seq_id, '0,
                                                        char_position, '0, req.ch));
        end
        live_founders = next_mask;
        char_position = char_position + 1;
        if (req.last)
        begin
            if (live_founders == '0)
                batch.insert(batch.size(), make_segment(KIND_NOT_FOUND, req.seq_id, '0,
                                                        char_position, '0, req.ch));
            else
                batch.insert(batch.size(), make_segment(KIND_RANGE, req.seq_id,
                                                        open_range_left, char_position,
                                                        live_founders, '0));
            live_founders   = ALL_FOUNDERS;
            open_range_left = '0;
            char_position   = '0;
        end
        if (batch.size() != 0)
            batch[batch.size()-1].end_of_results = 1'b1;
        foreach (batch[i])
            expected_segments.insert(expected_segments.size(), batch[i]);
    endtask

    task automatic add_char(input logic [ID_W-1:0] id, input logic [CHAR_W-1:0] ch,
                            input logic [COLUMN_W-1:0] column, input logic last);
        char_request_t req;
        req.seq_id = id;
        req.ch     = ch;
        req.column = column;
        req.last   = last;
        pending_chars.insert(pending_chars.size(), req);
    endtask

    // Prediction on accepted requests and checking of accepted results.
    always @(posedge clk)
    begin : check_proc
        char_request_t req;
        result_t       want;
        cycle_count++;
        calm_stretch = (cycle_count >= 150 && cycle_count < 300);
        request_taken = s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            req.seq_id = s_tdata[15:0];
            req.ch     = s_tdata[23:16];
            req.column = s_tdata[87:24];
            req.last   = s_tlast;
            predict_segments(req);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_segments.size() == 0)
                report_mismatch("result arrived with none expected");
            else
            begin
                want = expected_segments.pop_front();
                compare_field("kind", 32'(m_tuser), 32'(want.kind));
                compare_field("sequence_id", 32'(m_tdata[15:0]), 32'(want.seq_id));
                compare_field("range_start", m_tdata[47:16], want.range_start);
                compare_field("range_end", m_tdata[79:48], want.range_end);
                compare_field("matching_founders", 32'(m_tdata[87:80]),
                              32'(want.founders));
                compare_field("offending_char", 32'(m_tdata[95:88]),
                              32'(want.offending_char));
                compare_field("end_of_results", 32'(m_tlast), 32'(want.end_of_results));
            end
        end
    end

    // Request driver: holds a request until it is taken, idles now and then.
    always @(negedge clk)
    begin : driver_proc
        char_request_t req;
        if (rst_n && !(s_tvalid && !request_taken))
        begin
            if (pending_chars.size() != 0 && (calm_stretch || $urandom_range(0, 99) >= 20))
            begin
                req = pending_chars.pop_front();
                s_tdata  <= {req.column, req.ch, req.seq_id};
                s_tlast  <= req.last;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result receiver: stalls in about one cycle of five, never in the calm stretch.
    always @(negedge clk)
    begin
        m_tready <= rst_n && (calm_stretch || $urandom_range(0, 99) >= 20);
    end

    // Stimulus and end of run.
    initial
    begin : stimulus_proc
        int                  random_count;
        int                  seq_len;
        int                  follow;
        int                  k;
        int                  pick;
        logic                noisy;
        logic [ID_W-1:0]     id;
        logic [COLUMN_W-1:0] column;
        logic [CHAR_W-1:0]   ch;
        logic [CHAR_W-1:0]   bases[4];

        bases = '{CH_A, CH_C, CH_G, CH_T};

        // Field extremes on single-character sequences.
        add_char(16'h0000, 8'h00, '0, 1'b1);
        add_char(16'hFFFF, 8'hFF, '1, 1'b1);
        // Alternating founders: a range closes, then an unknown character on the last
        // position gives a closed range, a not-found error and a final error.
        add_char(16'h1234, 8'h55, 64'h55AA_55AA_55AA_55AA, 1'b0);
        add_char(16'h1234, 8'hAA, 64'h55AA_55AA_55AA_55AA, 1'b0);
        add_char(16'h1234, 8'h3C, {8{CH_A}}, 1'b1);
        // Error mid sequence, then the empty mask carried into the next character.
        add_char(16'h0777, CH_A, {8{CH_A}}, 1'b0);
        add_char(16'h0777, CH_C, {{7{CH_A}}, CH_C}, 1'b0);
        add_char(16'h0777, CH_G, {8{CH_A}}, 1'b0);
        add_char(16'h0777, CH_A, {8{CH_A}}, 1'b0);
        add_char(16'h0777, CH_T, {CH_T, {7{CH_A}}}, 1'b1);
        // Unknown character that is also the last one.
        add_char(16'hBEEF, 8'h00, '1, 1'b1);
        // Range split once inside one sequence, then narrowed to a single founder.
        add_char(16'h5A5A, CH_A, {{4{CH_C}}, {4{CH_A}}}, 1'b0);
        add_char(16'h5A5A, CH_C, {{4{CH_C}}, {4{CH_A}}}, 1'b0);
        add_char(16'h5A5A, CH_G, {CH_G, {7{CH_T}}}, 1'b0);
        add_char(16'h5A5A, CH_G, {8{CH_G}}, 1'b1);

        // Random sequences: mostly follow one founder with occasional switches and
        // strangers; some sequences are pure noise.
        random_count = 0;
        while (random_count < 150)
        begin
            seq_len = $urandom_range(1, 12);
            id      = ID_W'($urandom);
            follow  = $urandom_range(0, NUM_FOUNDERS - 1);
            noisy   = ($urandom_range(0, 9) == 0);
            for (int n = 0; n < seq_len; n++)
            begin
                for (k = 0; k < 8; k++)
                    column[8*k +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                                  : bases[$urandom_range(0, 3)];
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    follow = $urandom_range(0, NUM_FOUNDERS - 1);
                if (noisy || pick >= 92)
                    ch = CHAR_W'($urandom);
                else
                    ch = column[8*follow +: 8];
                add_char(id, ch, column, n == seq_len - 1);
                random_count++;
            end
        end

        @(posedge rst_n);
        while (pending_chars.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_segments.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("greedy_founder_segment_matcher_top test passed");
        else
            $display("greedy_founder_segment_matcher_top test failed");
        $finish;
    end

endmodule
